/* hw/rtl/vppu_pkg.sv */
// vppu_pkg: shared types, constants and the latency function of the
// vector plane projection unit
// no dependencies; used by the top level and its checker
package vppu_pkg;

	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 32;
	localparam int MIN_LEN_W = 17;
	localparam int COMP_W    = 32;
	localparam int NLANE     = 3;
	localparam int SQRT_W    = 32;
	localparam int SUMSQ_W   = 64;

	// register index, taken from paddr[CFG_AW-1]
	localparam logic REG_IDX_MIN_LEN = 1'b0;

	localparam logic signed [COMP_W-1:0] COMP_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COMP_W-1:0] COMP_MIN = 32'sh8000_0000;

	// three components, index 0 is x
	typedef logic [NLANE-1:0][COMP_W-1:0] vec3_t;

	// cycles from accepted start to the done strobe
	function automatic int vppu_latency(input int frac);
		return frac + 42;
	endfunction

endpackage

/* hw/rtl/vector_plane_projection_unit.sv */
// operands and results are fixed point with FRAC_BITS fraction bits (Q16.16 by default)
// throughput: one transaction per cycle; busy is always low
// the 32-stage square root pipeline and the FRAC_BITS+1 divider stages set the depth
// results appear on done for one cycle; the receiver cannot stall
// arst_n clears valid bits and the threshold register (0) asynchronously
// vector_plane_projection_unit: projects a vector onto the plane of a normal
// depends on vppu_pkg
module vector_plane_projection_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [vppu_pkg::CFG_AW-1:0]  paddr,
	input  logic [vppu_pkg::CFG_DW-1:0]  pwdata,
	output logic [vppu_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [31:0]           vec_x,
	input  logic signed [31:0]           vec_y,
	input  logic signed [31:0]           vec_z,
	input  logic signed [31:0]           normal_x,
	input  logic signed [31:0]           normal_y,
	input  logic signed [31:0]           normal_z,
	output logic                         done,
	output logic signed [31:0]           proj_x,
	output logic signed [31:0]           proj_y,
	output logic signed [31:0]           proj_z,
	output logic                         normal_degenerate,
	output logic                         result_saturated
);
	import vppu_pkg::*;

	localparam int NUM_W     = COMP_W + FRAC_BITS;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int DOT_W     = SUMSQ_W + 2;
	localparam int D_W       = DOT_W - FRAC_BITS;
	localparam int PL_W      = 2 * COMP_W + 1;
	localparam int FULL_W    = D_W + COMP_W;
	localparam int RES_W     = FULL_W + 1;
	localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(COMP_MAX);
	localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(COMP_MIN);

	// configuration register
	logic [MIN_LEN_W-1:0] min_len_q;
	logic                 cfg_hit;
	assign cfg_hit = (paddr[CFG_AW-1] == REG_IDX_MIN_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= '0;
		end else if (psel && penable && pwrite && cfg_hit) begin
			min_len_q <= pwdata[MIN_LEN_W-1:0];
		end
	end

	assign prdata = cfg_hit ? CFG_DW'(min_len_q) : '0;
	assign pready = 1'b1;
	assign busy   = 1'b0;

	logic  accept;
	assign accept = start & ~busy;

	vec3_t v_in, n_in;
	assign v_in = {vec_z, vec_y, vec_x};
	assign n_in = {normal_z, normal_y, normal_x};

	// stage 1: squares of the normal components
	logic                          vld_s1;
	vec3_t                         v_s1, n_s1;
	logic [NLANE-1:0][SUMSQ_W-1:0] sq_s1;
	wire  [NLANE-1:0][SUMSQ_W-1:0] sq_c;

	for (genvar l = 0; l < NLANE; l++) begin : g_sq
		wire signed [SUMSQ_W-1:0] prod;
		assign prod    = $signed(n_in[l]) * $signed(n_in[l]);
		assign sq_c[l] = prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		v_s1  <= v_in;
		n_s1  <= n_in;
		sq_s1 <= sq_c;
	end

	// stage 2 and square root stages, one result bit per stage
	logic               sqrt_vld_s  [SQRT_W+1];
	logic [SUMSQ_W-1:0] sqrt_rem_s  [SQRT_W+1];
	logic [SQRT_W-1:0]  sqrt_root_s [SQRT_W+1];
	vec3_t              sqrt_v_s    [SQRT_W+1];
	vec3_t              sqrt_n_s    [SQRT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqrt_vld_s[0] <= 1'b0;
		end else begin
			sqrt_vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqrt_rem_s[0]  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		sqrt_root_s[0] <= '0;
		sqrt_v_s[0]    <= v_s1;
		sqrt_n_s[0]    <= n_s1;
	end

	for (genvar k = 0; k < SQRT_W; k++) begin : g_sqrt
		localparam int BIT = SQRT_W - 1 - k;
		wire [SUMSQ_W+1:0] trial;
		wire               take;
		assign trial = ((SUMSQ_W+2)'(sqrt_root_s[k]) << (BIT + 1)) |
			((SUMSQ_W+2)'(1) << (2 * BIT));
		assign take  = ({2'b00, sqrt_rem_s[k]} >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqrt_vld_s[k+1] <= 1'b0;
			end else begin
				sqrt_vld_s[k+1] <= sqrt_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sqrt_rem_s[k+1]  <= take ? (sqrt_rem_s[k] - trial[SUMSQ_W-1:0]) : sqrt_rem_s[k];
			sqrt_root_s[k+1] <= take ? (sqrt_root_s[k] | (SQRT_W'(1) << BIT)) :
				sqrt_root_s[k];
			sqrt_v_s[k+1]    <= sqrt_v_s[k];
			sqrt_n_s[k+1]    <= sqrt_n_s[k];
		end
	end

	// stage 3: threshold compare and divider setup
	logic                        div_vld_s [DIV_STEPS+1];
	logic                        div_deg_s [DIV_STEPS+1];
	logic [SQRT_W-1:0]           div_len_s [DIV_STEPS+1];
	logic [NLANE-1:0][NUM_W-1:0] div_rem_s [DIV_STEPS+1];
	logic [NLANE-1:0][QUO_W-1:0] div_q_s   [DIV_STEPS+1];
	vec3_t                       div_v_s   [DIV_STEPS+1];
	vec3_t                       div_n_s   [DIV_STEPS+1];
	wire  [NLANE-1:0][NUM_W-1:0] num_c;

	for (genvar l = 0; l < NLANE; l++) begin : g_num
		wire [COMP_W-1:0] nc, mag;
		assign nc       = sqrt_n_s[SQRT_W][l];
		assign mag      = nc[COMP_W-1] ? (~nc + COMP_W'(1)) : nc;
		assign num_c[l] = {mag, {FRAC_BITS{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else begin
			div_vld_s[0] <= sqrt_vld_s[SQRT_W];
		end
	end

	always_ff @(posedge clk) begin
		div_deg_s[0] <= !(sqrt_root_s[SQRT_W] > SQRT_W'(min_len_q));
		div_len_s[0] <= sqrt_root_s[SQRT_W];
		div_rem_s[0] <= num_c;
		div_q_s[0]   <= '0;
		div_v_s[0]   <= sqrt_v_s[SQRT_W];
		div_n_s[0]   <= sqrt_n_s[SQRT_W];
	end

	// restoring divider, one quotient bit per stage, three lanes
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int BIT = FRAC_BITS - j;
		wire [NUM_W-1:0]             dsh;
		wire [NLANE-1:0][NUM_W-1:0]  rem_nx;
		wire [NLANE-1:0][QUO_W-1:0]  q_nx;
		assign dsh = NUM_W'(div_len_s[j]) << BIT;

		for (genvar l = 0; l < NLANE; l++) begin : g_lane
			wire take;
			assign take      = (div_rem_s[j][l] >= dsh);
			assign rem_nx[l] = take ? (div_rem_s[j][l] - dsh) : div_rem_s[j][l];
			assign q_nx[l]   = take ? (div_q_s[j][l] | (QUO_W'(1) << BIT)) : div_q_s[j][l];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[j+1] <= 1'b0;
			end else begin
				div_vld_s[j+1] <= div_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			div_deg_s[j+1] <= div_deg_s[j];
			div_len_s[j+1] <= div_len_s[j];
			div_rem_s[j+1] <= rem_nx;
			div_q_s[j+1]   <= q_nx;
			div_v_s[j+1]   <= div_v_s[j];
			div_n_s[j+1]   <= div_n_s[j];
		end
	end

	// stage 4: unit normal or raw normal when degenerate
	logic  vld_s4, deg_s4;
	vec3_t v_s4, u_s4;
	wire [NLANE-1:0][COMP_W-1:0] u_c;

	for (genvar l = 0; l < NLANE; l++) begin : g_u
		wire [COMP_W-1:0] q32, nn;
		assign q32    = COMP_W'(div_q_s[DIV_STEPS][l]);
		assign nn     = div_n_s[DIV_STEPS][l];
		assign u_c[l] = div_deg_s[DIV_STEPS] ? nn :
			(nn[COMP_W-1] ? (~q32 + COMP_W'(1)) : q32);
	end

	// stage 5: v times u per component
	logic                          vld_s5, deg_s5;
	vec3_t                         v_s5, u_s5;
	logic [NLANE-1:0][SUMSQ_W-1:0] p_s5;
	wire  [NLANE-1:0][SUMSQ_W-1:0] p_c;

	for (genvar l = 0; l < NLANE; l++) begin : g_dot
		wire signed [SUMSQ_W-1:0] prod;
		assign prod   = $signed(v_s4[l]) * $signed(u_s4[l]);
		assign p_c[l] = prod;
	end

	// stage 6: dot product, floored to FRAC_BITS
	logic                  vld_s6, deg_s6;
	vec3_t                 v_s6, u_s6;
	logic [D_W-1:0]        d_s6;
	wire signed [DOT_W-1:0] dot_c, dot_sh;
	assign dot_c  = $signed(p_s5[0]) + $signed(p_s5[1]) + $signed(p_s5[2]);
	assign dot_sh = dot_c >>> FRAC_BITS;

	// stage 7: d times u as two partial products
	logic                       vld_s7, deg_s7;
	vec3_t                      v_s7;
	logic [NLANE-1:0][PL_W-1:0] pl_s7;
	logic [NLANE-1:0][D_W-1:0]  ph_s7;
	wire  [NLANE-1:0][PL_W-1:0] pl_c;
	wire  [NLANE-1:0][D_W-1:0]  ph_c;

	for (genvar l = 0; l < NLANE; l++) begin : g_term
		wire signed [PL_W-1:0] lo;
		wire signed [D_W-1:0]  hi;
		assign lo      = $signed({1'b0, d_s6[COMP_W-1:0]}) * $signed(u_s6[l]);
		assign hi      = $signed(d_s6[D_W-1:COMP_W]) * $signed(u_s6[l]);
		assign pl_c[l] = lo;
		assign ph_c[l] = hi;
	end

	// stage 8: combine partial products
	logic                         vld_s8, deg_s8;
	vec3_t                        v_s8;
	logic [NLANE-1:0][FULL_W-1:0] full_s8;
	wire  [NLANE-1:0][FULL_W-1:0] full_c;

	for (genvar l = 0; l < NLANE; l++) begin : g_full
		wire signed [FULL_W-1:0] hi_ext, lo_ext;
		assign hi_ext    = {ph_s7[l], {COMP_W{1'b0}}};
		assign lo_ext    = $signed(pl_s7[l]);
		assign full_c[l] = hi_ext + lo_ext;
	end

	// stage 9: subtract, clamp and present the result
	logic                   vld_s9, deg_s9, sat_s9;
	vec3_t                  proj_s9;
	wire  [NLANE-1:0][COMP_W-1:0] proj_c;
	wire  [NLANE-1:0]       sat_c;

	for (genvar l = 0; l < NLANE; l++) begin : g_clamp
		wire signed [FULL_W-1:0] t;
		wire signed [RES_W-1:0]  r;
		wire                     hi, lo;
		assign t         = $signed(full_s8[l]) >>> FRAC_BITS;
		assign r         = $signed(v_s8[l]) - t;
		assign hi        = (r > RES_MAX);
		assign lo        = (r < RES_MIN);
		assign proj_c[l] = hi ? COMP_MAX : (lo ? COMP_MIN : r[COMP_W-1:0]);
		assign sat_c[l]  = hi | lo;
	end

	// valid bits of the back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s4 <= div_vld_s[DIV_STEPS];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// payload of the back stages
	always_ff @(posedge clk) begin
		deg_s4  <= div_deg_s[DIV_STEPS];
		v_s4    <= div_v_s[DIV_STEPS];
		u_s4    <= u_c;
		deg_s5  <= deg_s4;
		v_s5    <= v_s4;
		u_s5    <= u_s4;
		p_s5    <= p_c;
		deg_s6  <= deg_s5;
		v_s6    <= v_s5;
		u_s6    <= u_s5;
		d_s6    <= dot_sh[D_W-1:0];
		deg_s7  <= deg_s6;
		v_s7    <= v_s6;
		pl_s7   <= pl_c;
		ph_s7   <= ph_c;
		deg_s8  <= deg_s7;
		v_s8    <= v_s7;
		full_s8 <= full_c;
		deg_s9  <= deg_s8;
		proj_s9 <= proj_c;
		sat_s9  <= |sat_c;
	end

	assign done              = vld_s9;
	assign proj_x            = $signed(proj_s9[0]);
	assign proj_y            = $signed(proj_s9[1]);
	assign proj_z            = $signed(proj_s9[2]);
	assign normal_degenerate = deg_s9;
	assign result_saturated  = sat_s9;

endmodule

/* hw/rtl/vppu_checker.sv */
// vppu_checker: port-level assertions for vector_plane_projection_unit,
// bound to the top level at the end of this file
// depends on vppu_pkg
module vppu_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [vppu_pkg::CFG_AW-1:0]  paddr,
	input logic [vppu_pkg::CFG_DW-1:0]  pwdata,
	input logic [vppu_pkg::CFG_DW-1:0]  prdata,
	input logic                         pready,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic signed [31:0]           proj_x,
	input logic signed [31:0]           proj_y,
	input logic signed [31:0]           proj_z,
	input logic                         normal_degenerate,
	input logic                         result_saturated
);
	import vppu_pkg::*;

	localparam int LAT   = vppu_latency(FRAC_BITS);
	localparam int CNT_W = $clog2(LAT + 2);

	// cycles since reset release, saturating
	logic [CNT_W-1:0] warm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != CNT_W'(LAT + 1)) begin
			warm_q <= warm_q + CNT_W'(1);
		end
	end

	// the pipeline never holds off a transaction
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// each accepted transaction gives one result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == CNT_W'(LAT + 1)) |-> (done == $past(start && !busy, LAT)))
		else $error("result strobe out of step with accepted transactions");

	// a saturated result has a component on a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result_saturated) |->
		(proj_x == COMP_MAX || proj_x == COMP_MIN || proj_y == COMP_MAX ||
		 proj_y == COMP_MIN || proj_z == COMP_MAX || proj_z == COMP_MIN))
		else $error("saturation flag without a clamped component");

	// threshold write reads back masked to its width
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		((warm_q != '0) &&
		 $past(psel && penable && pwrite && pready &&
		       (paddr[CFG_AW-1] == REG_IDX_MIN_LEN)) &&
		 (paddr[CFG_AW-1] == REG_IDX_MIN_LEN)) |->
		(prdata == CFG_DW'($past(pwdata[MIN_LEN_W-1:0]))))
		else $error("threshold readback mismatch");

endmodule

bind vector_plane_projection_unit vppu_checker #(.FRAC_BITS(FRAC_BITS)) u_vppu_checker (.*);
